// ===== rtl/core/swtq_pkg.sv =====
package swtq_pkg;

	localparam int unsigned IdW    = 8;
	localparam int unsigned DelayW = 32;
	localparam int unsigned CountW = 63;
	localparam int unsigned WakeW  = 64;
	localparam int unsigned KindW  = 2;
	localparam int unsigned MaxResults = 16;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_SLEEP = 1'b1;

	localparam logic [KindW-1:0] KIND_WOKEN    = 2'd0;
	localparam logic [KindW-1:0] KIND_ACCEPTED = 2'd1;
	localparam logic [KindW-1:0] KIND_NEGATIVE = 2'd2;
	localparam logic [KindW-1:0] KIND_FULL     = 2'd3;

	typedef struct packed {
		logic              command;
		logic [IdW-1:0]    requester_id;
		logic [DelayW-1:0] delay_ticks;
	} in_item_t;

	typedef struct packed {
		logic [KindW-1:0]  result_kind;
		logic [IdW-1:0]    woken_id;
		logic [CountW-1:0] tick_count;
		logic              last;
	} out_item_t;

	// Classified operation passed from front to back.
	typedef struct packed {
		logic              is_tick;
		logic [IdW-1:0]    id;
		logic [DelayW-1:0] delay;
	} op_t;

endpackage

// ===== rtl/core/swtq_if.sv =====
interface swtq_in_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [swtq_pkg::IdW-1:0]   requester_id;
	logic [swtq_pkg::DelayW-1:0] delay_ticks;
	modport source (output valid, command, requester_id, delay_ticks, input ready);
	modport sink (input valid, command, requester_id, delay_ticks, output ready);
endinterface

interface swtq_out_if;
	logic                        valid;
	logic                        ready;
	logic [swtq_pkg::KindW-1:0]  result_kind;
	logic [swtq_pkg::IdW-1:0]    woken_id;
	logic [swtq_pkg::CountW-1:0] tick_count;
	logic                        last;
	modport source (output valid, result_kind, woken_id, tick_count, last, input ready);
	modport sink (input valid, result_kind, woken_id, tick_count, last, output ready);
endinterface

// ===== rtl/core/swtq_fifo.sv =====
module swtq_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  swtq_pkg::op_t     push_data,
	output logic              full,
	input  logic              pop,
	output swtq_pkg::op_t     pop_data,
	output logic              empty
);
	swtq_pkg::op_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule

// ===== rtl/core/swtq_back.sv =====
module swtq_back #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	input  swtq_pkg::op_t        op,
	output logic                 op_pop,
	output logic                 res_valid,
	output swtq_pkg::out_item_t  res,
	input  logic                 res_ready,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill
);
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned NW   = $clog2(swtq_pkg::MaxResults + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAKE = 2'd1;

	logic [swtq_pkg::WakeW-1:0]  wake_q  [QUEUE_DEPTH];
	logic [swtq_pkg::IdW-1:0]    owner_q [QUEUE_DEPTH];
	logic [CntW-1:0]             cnt_q;
	logic [swtq_pkg::CountW-1:0] tick_q;
	logic [1:0]                  st_q;
	logic [NW-1:0]               n_q;
	logic                        ovalid_q;
	swtq_pkg::out_item_t         out_q;

	logic                        slot_free;
	logic [swtq_pkg::WakeW-1:0]  new_wake;
	logic [QUEUE_DEPTH-1:0]      after;
	logic                        due, due_next, insert;

	assign slot_free = !ovalid_q || res_ready;
	assign res_valid = ovalid_q;
	assign res       = out_q;
	assign fill      = cnt_q;
	assign new_wake  = {1'b0, tick_q} + {{(swtq_pkg::WakeW-swtq_pkg::DelayW){1'b0}}, op.delay};
	assign due       = (cnt_q != '0) && (wake_q[0] <= {1'b0, tick_q});
	assign due_next  = (cnt_q > CntW'(1)) && (wake_q[1] <= {1'b0, tick_q});
	// Only a non-negative sleep with a free slot goes into the queue.
	assign insert    = st_q == ST_IDLE && op_valid && slot_free && !op.is_tick &&
	                   !op.delay[swtq_pkg::DelayW-1] && cnt_q != CntW'(QUEUE_DEPTH);
	assign op_pop    = st_q == ST_IDLE && op_valid && slot_free;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			after[i] = (CntW'(i) < cnt_q) && (wake_q[i] > new_wake);
		end
	end

	// Shift-register sorted queue: insert in one step, pop one per cycle while the result slot is free.
	always_ff @(posedge clk) begin
		if (insert) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (after[i]) begin
					if (i + 1 < QUEUE_DEPTH) begin
						wake_q[(i+1) % QUEUE_DEPTH]  <= wake_q[i];
						owner_q[(i+1) % QUEUE_DEPTH] <= owner_q[i];
					end
				end
				if ((after[i] || CntW'(i) == cnt_q) &&
				    (i == 0 || !after[(i+QUEUE_DEPTH-1) % QUEUE_DEPTH])) begin
					wake_q[i]  <= new_wake;
					owner_q[i] <= op.id;
				end
			end
		end else if (st_q == ST_WAKE && slot_free && due) begin
			for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
				wake_q[i]  <= wake_q[i+1];
				owner_q[i] <= owner_q[i+1];
			end
		end
		if (slot_free) begin
			if (st_q == ST_IDLE && op_valid && !op.is_tick) begin
				out_q.woken_id   <= op.id;
				out_q.tick_count <= tick_q;
				out_q.last       <= 1'b1;
				if (op.delay[swtq_pkg::DelayW-1])
					out_q.result_kind <= swtq_pkg::KIND_NEGATIVE;
				else if (cnt_q == CntW'(QUEUE_DEPTH))
					out_q.result_kind <= swtq_pkg::KIND_FULL;
				else
					out_q.result_kind <= swtq_pkg::KIND_ACCEPTED;
			end else if (st_q == ST_WAKE && due) begin
				out_q.woken_id    <= owner_q[0];
				out_q.tick_count  <= tick_q;
				out_q.result_kind <= swtq_pkg::KIND_WOKEN;
				out_q.last <= !due_next || (n_q == NW'(swtq_pkg::MaxResults - 1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			tick_q   <= '0;
			st_q     <= ST_IDLE;
			n_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (res_ready) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (op_valid && slot_free) begin
						if (op.is_tick) begin
							tick_q <= tick_q + 1'b1;
							n_q    <= '0;
							st_q   <= ST_WAKE;
						end else begin
							ovalid_q <= 1'b1;
							if (!op.delay[swtq_pkg::DelayW-1] && cnt_q != CntW'(QUEUE_DEPTH))
								cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_WAKE: begin
					if (slot_free) begin
						if (due && n_q != NW'(swtq_pkg::MaxResults)) begin
							ovalid_q <= 1'b1;
							cnt_q    <= cnt_q - 1'b1;
							n_q      <= n_q + 1'b1;
							if (!due_next || n_q == NW'(swtq_pkg::MaxResults - 1))
								st_q <= ST_IDLE;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/sorted_wakeup_timer_queue.sv =====
// Sorted wake-up timer queue. Each request is either a tick (command 0) or a
// sleep (command 1). A sleep answers with one result (accepted, negative delay
// ignored, or queue full) and, when accepted, schedules its id at tick_count +
// delay, behind any equal wake times. A tick advances the count and then wakes
// due entries front first, one result per cycle, up to 16 per tick, marking the
// final one with last; a tick with nobody due gives no result. A front stage
// takes requests into a two-entry queue; a back stage holds the sorted
// shift-register queue. A request goes from the two-entry queue to the back
// stage, which registers its result. A tick advances the count in the idle
// state, then the wake state pops one due entry per result, or only checks
// the front when nobody is due. Only the front of the sorted queue is popped,
// and a stalled result register holds the back stage until it is taken.
module sorted_wakeup_timer_queue #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	swtq_in_if.sink    in_ch,
	swtq_out_if.source out_ch
);
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	swtq_pkg::op_t       push_op, head_op;
	swtq_pkg::out_item_t res;
	logic                fifo_full, fifo_empty, op_pop, res_valid;
	logic [CntW-1:0]     fill;

	// Front: accept request whenever the hand-off queue has room.
	assign in_ch.ready     = !fifo_full;
	assign push_op.is_tick = (in_ch.command == swtq_pkg::CMD_TICK);
	assign push_op.id      = in_ch.requester_id;
	assign push_op.delay   = in_ch.delay_ticks;

	swtq_fifo u_fifo (
		.clk, .arst_n,
		.push      (in_ch.valid),
		.push_data (push_op),
		.full      (fifo_full),
		.pop       (op_pop),
		.pop_data  (head_op),
		.empty     (fifo_empty)
	);

	// Back: sorted queue and result register.
	swtq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n,
		.op_valid  (!fifo_empty),
		.op        (head_op),
		.op_pop    (op_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (out_ch.ready),
		.fill      (fill)
	);

	assign out_ch.valid       = res_valid;
	assign out_ch.result_kind = res.result_kind;
	assign out_ch.woken_id    = res.woken_id;
	assign out_ch.tick_count  = res.tick_count;
	assign out_ch.last        = res.last;

`ifndef NO_ASSERTIONS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CntW'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");
	a_sleep_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.result_kind != swtq_pkg::KIND_WOKEN |-> out_ch.last)
		else $error("sleep answer without last");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill != $past(fill) |-> fill == $past(fill) + 1'b1 || fill == $past(fill) - 1'b1)
		else $error("fill moved by more than one");
`endif
endmodule

// ===== sim/tb_sorted_wakeup_timer_queue.sv =====
`timescale 1ns / 100ps

// Check the sorted wake-up timer queue: a predictor keeps its own copy of the
// tick count and the sorted sleeper list, and each result coming out of the block
// is compared field by field with the oldest predicted result.
module tb_sorted_wakeup_timer_queue;

	localparam int unsigned Depth = 16;

	logic clk;
	logic arst_n;

	swtq_in_if  req_if ();
	swtq_out_if rsp_if ();

	sorted_wakeup_timer_queue #(.QUEUE_DEPTH(Depth)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_if.sink),
		.out_ch (rsp_if.source)
	);

	// Requests that wait to be driven, and results that the predictor expects.
	swtq_pkg::in_item_t  pending_reqs[$];
	swtq_pkg::out_item_t expected_wakes[$];

	// Predictor state: the tick count and the sleeper list, earliest wake first.
	logic [swtq_pkg::CountW-1:0] model_count;
	logic [swtq_pkg::WakeW-1:0]  model_wake[$];
	logic [swtq_pkg::IdW-1:0]    model_owner[$];

	int  fail_count;
	int  sink_hold;   // cycles that the receiver holds off, counted down by the monitor
	bit  src_pause;   // the driver stops offering requests while this is set
	int  src_gap;
	int  sink_gap;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Pick a gap length: mostly none, often short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Compute the results of one request and update the predictor state.
	task automatic predict_request(input swtq_pkg::in_item_t rq);
		swtq_pkg::out_item_t        res;
		logic [swtq_pkg::WakeW-1:0] wake;
		int                         pos;
		int                         woken;
		res = '0;
		res.woken_id = rq.requester_id;
		res.last = 1'b1;
		if (rq.command == swtq_pkg::CMD_SLEEP) begin
			res.tick_count = model_count;
			if (rq.delay_ticks[swtq_pkg::DelayW-1]) begin
				res.result_kind = swtq_pkg::KIND_NEGATIVE;
			end else if (model_wake.size() >= Depth) begin
				res.result_kind = swtq_pkg::KIND_FULL;
			end else begin
				wake = {1'b0, model_count} + {32'd0, rq.delay_ticks};
				pos = 0;
				// Go behind every entry with an equal wake time.
				while (pos < model_wake.size() && model_wake[pos] <= wake) pos++;
				model_wake.insert(pos, wake);
				model_owner.insert(pos, rq.requester_id);
				res.result_kind = swtq_pkg::KIND_ACCEPTED;
			end
			expected_wakes.push_back(res);
		end else begin
			model_count = model_count + 1'b1;
			woken = 0;
			while (woken < swtq_pkg::MaxResults && model_wake.size() > 0 &&
					model_wake[0] <= {1'b0, model_count}) begin
				res.result_kind = swtq_pkg::KIND_WOKEN;
				res.woken_id = model_owner.pop_front();
				void'(model_wake.pop_front());
				res.tick_count = model_count;
				res.last = 1'b0;
				expected_wakes.push_back(res);
				woken++;
			end
			// Mark the final wake of this tick.
			if (woken > 0) expected_wakes[$].last = 1'b1;
		end
	endtask

	function automatic swtq_pkg::in_item_t make_tick();
		swtq_pkg::in_item_t rq;
		rq.command = swtq_pkg::CMD_TICK;
		rq.requester_id = 8'($urandom());
		rq.delay_ticks = $urandom();
		return rq;
	endfunction

	function automatic swtq_pkg::in_item_t make_sleep(input logic [swtq_pkg::DelayW-1:0] dly);
		swtq_pkg::in_item_t rq;
		rq.command = swtq_pkg::CMD_SLEEP;
		rq.requester_id = 8'($urandom());
		rq.delay_ticks = dly;
		return rq;
	endfunction

	// Driver: present the head of the pending queue, predict it on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid        <= 1'b0;
			req_if.command      <= swtq_pkg::CMD_TICK;
			req_if.requester_id <= '0;
			req_if.delay_ticks  <= '0;
			src_gap             <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				predict_request(pending_reqs.pop_front());
			end
			if (req_if.valid && !req_if.ready) begin
				// Hold the request until it is taken.
			end else if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				req_if.valid <= 1'b0;
			end else if (!src_pause && pending_reqs.size() > 0) begin
				// After an accept the next request sits at index 0 of the updated queue.
				req_if.valid        <= 1'b1;
				req_if.command      <= pending_reqs[0].command;
				req_if.requester_id <= pending_reqs[0].requester_id;
				req_if.delay_ticks  <= pending_reqs[0].delay_ticks;
				if (req_if.valid && req_if.ready) src_gap <= pick_gap();
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result and throttle ready.
	always @(posedge clk or negedge arst_n) begin
		swtq_pkg::out_item_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			sink_gap     <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_wakes.size() == 0) begin
					$error("result with nothing expected: kind %0d id %0d",
						rsp_if.result_kind, rsp_if.woken_id);
					fail_count++;
				end else begin
					want = expected_wakes.pop_front();
					if (rsp_if.result_kind !== want.result_kind) begin
						$error("result_kind: expected %0d, got %0d",
							want.result_kind, rsp_if.result_kind);
						fail_count++;
					end
					if (rsp_if.woken_id !== want.woken_id) begin
						$error("woken_id: expected %0d, got %0d",
							want.woken_id, rsp_if.woken_id);
						fail_count++;
					end
					if (rsp_if.tick_count !== want.tick_count) begin
						$error("tick_count: expected %0d, got %0d",
							want.tick_count, rsp_if.tick_count);
						fail_count++;
					end
					if (rsp_if.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp_if.last);
						fail_count++;
					end
				end
			end
			if (sink_hold > 0) begin
				sink_hold    <= sink_hold - 1;
				rsp_if.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap     <= sink_gap - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				if (rsp_if.ready && rsp_if.valid) sink_gap <= pick_gap();
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req_if.valid || expected_wakes.size() > 0)
			@(posedge clk);
	endtask

	// Queue a batch of random ticks and sleeps: mostly short delays so sleepers wake
	// and tie, some big ones and some negative ones.
	task automatic push_random(input int count);
		int r;
		logic [swtq_pkg::DelayW-1:0] dly;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				pending_reqs.push_back(make_tick());
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) dly = $urandom_range(0, 6);
				else if (r < 85) dly = $urandom() & 32'h7FFF_FFFF;
				else dly = $urandom() | 32'h8000_0000;
				pending_reqs.push_back(make_sleep(dly));
			end
		end
	endtask

	initial begin
		fail_count = 0;
		sink_hold  = 0;
		src_pause  = 1'b0;
		model_count = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero delay, extremes, negative, ties, tick with nobody due.
		pending_reqs.push_back(make_sleep(32'd0));
		pending_reqs.push_back(make_sleep(32'h7FFF_FFFF));
		pending_reqs.push_back(make_sleep(32'h8000_0000));
		pending_reqs.push_back(make_sleep(32'hFFFF_FFFF));
		pending_reqs.push_back(make_sleep(32'd2));
		pending_reqs.push_back(make_sleep(32'd2));
		pending_reqs.push_back(make_sleep(32'd1));
		pending_reqs.push_back('{command: swtq_pkg::CMD_TICK, requester_id: 8'hFF,
			delay_ticks: 32'hFFFF_FFFF});
		pending_reqs.push_back(make_tick());
		pending_reqs.push_back(make_tick());
		pending_reqs.push_back(make_tick());
		// Fill past the depth so requests get refused as full.
		repeat (Depth + 1) pending_reqs.push_back(make_sleep(32'd3));
		pending_reqs.push_back(make_sleep(32'h8000_0000));
		repeat (4) pending_reqs.push_back(make_tick());

		// Receiver holds off long while the sender keeps offering requests.
		sink_hold = 150;
		wait_drained();

		push_random(180);
		// Sender pauses midway until every expected result has come.
		while (pending_reqs.size() > 100) @(posedge clk);
		src_pause = 1'b1;
		while (req_if.valid || expected_wakes.size() > 0) @(posedge clk);
		src_pause = 1'b0;

		push_random(180);
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_wakes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Guard the run against a hang.
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
